### rtl/esc_pkg.sv
package esc_pkg;

   // Field widths
   localparam int SecsWidth    = 32;
   localparam int YearWidth    = 7;
   localparam int MonthWidth   = 4;
   localparam int DayWidth     = 5;
   localparam int HourWidth    = 5;
   localparam int MinuteWidth  = 6;
   localparam int SecondWidth  = 6;
   localparam int WeekdayWidth = 3;

   // Internal widths
   localparam int DaysWidth    = 16;   // whole days, up to 49710
   localparam int TodWidth     = 17;   // second of day, below 86400
   localparam int MinOfDayWidth = 11;  // minute of day, below 1440
   localparam int GroupWidth   = 6;    // four-year group index
   localparam int GroupRemWidth = 11;  // day within group, below 1461
   localparam int YearRemWidth = 9;    // day within year, below 366

   // Pipeline depth
   localparam int NumStages = 6;

   // Calendar constants
   localparam int SecsPerDay    = 86400;
   localparam int SecsPerMinute = 60;
   localparam int MinsPerHour   = 60;
   localparam int DaysPerGroup  = 1461;
   localparam int DaysPerWeek   = 7;
   // 2000-01-01 was a Saturday
   localparam int FirstWeekday  = 6;
   localparam logic [DaysWidth-1:0] DaysInRange = 16'd36525;

   typedef logic [YearRemWidth-1:0] cum_day_type;

   // First day of each month within a year, plus the year length
   localparam cum_day_type CumCommon [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };
   localparam cum_day_type CumLeap [13] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
   };

   // First day of the second, third and fourth year of a group
   localparam logic [GroupRemWidth-1:0] YearStart1 = 11'd366;
   localparam logic [GroupRemWidth-1:0] YearStart2 = 11'd731;
   localparam logic [GroupRemWidth-1:0] YearStart3 = 11'd1096;

   // Per-stage load enables and occupancy
   typedef struct packed {
      logic [NumStages-1:0] en;
      logic [NumStages-1:0] valid;
   } pipe_ctl_type;

endpackage

### rtl/esc_ifs.sv
interface esc_req_if;
   import esc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [SecsWidth-1:0] seconds_count;

   modport source (output valid, output seconds_count, input ready);
   modport sink   (input valid, input seconds_count, output ready);
endinterface

interface esc_rsp_if;
   import esc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [YearWidth-1:0]    year;
   logic [MonthWidth-1:0]   month;
   logic [DayWidth-1:0]     day;
   logic [HourWidth-1:0]    hour;
   logic [MinuteWidth-1:0]  minute;
   logic [SecondWidth-1:0]  second;
   logic [WeekdayWidth-1:0] weekday;
   logic                    out_of_range;

   modport source (output valid, output year, output month, output day, output hour,
                   output minute, output second, output weekday, output out_of_range,
                   input ready);
   modport sink   (input valid, input year, input month, input day, input hour,
                   input minute, input second, input weekday, input out_of_range,
                   output ready);
endinterface

### rtl/esc_pipe_ctrl.sv
module esc_pipe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output esc_pkg::pipe_ctl_type ctl
);
   import esc_pkg::*;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] prev_valid;
   logic [NumStages:0]   ready;

   // A stage takes a new item when it is empty or its content moves on
   always_comb begin
      ready[NumStages] = out_ready;
      for (int k = NumStages - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      prev_valid = {valid_ff[NumStages-2:0], in_valid};
      for (int k = 0; k < NumStages; k++) begin
         valid_in[k] = ready[k] ? prev_valid[k] : valid_ff[k];
      end
      ctl.en    = ready[NumStages-1:0] & prev_valid;
      ctl.valid = valid_ff;
   end

   // Advance occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NumStages-1];

   // Occupancy tracks transfers in and out exactly
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         ($countones(valid_ff) + $past(int'(out_valid && out_ready))) ==
         ($past($countones(valid_ff)) + $past(int'(in_valid && in_ready))))
      else $error("pipeline occupancy does not match transfers");

   // Any empty stage lets the input side move
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff) |-> in_ready)
      else $error("input stalled with an empty stage");

endmodule

### rtl/esc_day_split.sv
module esc_day_split (
   input  logic                            clock,
   input  esc_pkg::pipe_ctl_type           ctl,
   input  logic [esc_pkg::SecsWidth-1:0]   seconds_count,
   output logic [esc_pkg::DaysWidth-1:0]   days,
   output logic [esc_pkg::TodWidth-1:0]    tod
);
   import esc_pkg::*;

   // seconds / 86400 = (seconds >> 7) / 675
   localparam int LowBits  = 7;
   localparam int DayPart  = SecsPerDay >> LowBits;
   localparam int HiWidth  = SecsWidth - LowBits;
   localparam int RecipShift = 35;
   localparam int RecipWidth = 26;
   localparam int ProdWidth  = HiWidth + RecipWidth;
   localparam logic [RecipWidth-1:0] DayRecip =
      RecipWidth'((64'd1 << RecipShift) / 64'd675);
   localparam int RemWidth = 11;

   logic [ProdWidth-1:0] est_prod;
   logic [DaysWidth-1:0] est_ff;
   logic [SecsWidth-1:0] secs_ff;
   logic [HiWidth-1:0]   hi_rem;
   logic [RemWidth-1:0]  rem;
   logic                 fix;
   logic [RemWidth-1:0]  rem_fixed;
   logic [DaysWidth-1:0] days_in;
   logic [TodWidth-1:0]  tod_in;
   logic [DaysWidth-1:0] days_ff;
   logic [TodWidth-1:0]  tod_ff;

   // Stage 1: estimate day count, low by at most one
   assign est_prod = ProdWidth'(seconds_count[SecsWidth-1:LowBits]) *
                     ProdWidth'(DayRecip);

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         est_ff  <= est_prod[RecipShift +: DaysWidth];
         secs_ff <= seconds_count;
      end
   end

   // Stage 2: correct the estimate and rebuild the second of day
   always_comb begin
      hi_rem    = secs_ff[SecsWidth-1:LowBits] - HiWidth'(est_ff) * HiWidth'(DayPart);
      rem       = hi_rem[RemWidth-1:0];
      fix       = rem >= RemWidth'(DayPart);
      rem_fixed = fix ? rem - RemWidth'(DayPart) : rem;
      days_in   = est_ff + DaysWidth'(fix);
      tod_in    = {rem_fixed[TodWidth-LowBits-1:0], secs_ff[LowBits-1:0]};
   end

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         days_ff <= days_in;
         tod_ff  <= tod_in;
      end
   end

   assign days = days_ff;
   assign tod  = tod_ff;

endmodule

### rtl/esc_tod_split.sv
module esc_tod_split (
   input  logic                             clock,
   input  esc_pkg::pipe_ctl_type            ctl,
   input  logic [esc_pkg::TodWidth-1:0]     tod,
   output logic [esc_pkg::HourWidth-1:0]    hour,
   output logic [esc_pkg::MinuteWidth-1:0]  minute,
   output logic [esc_pkg::SecondWidth-1:0]  second
);
   import esc_pkg::*;

   localparam int MinShift  = 17;
   localparam int MinRecipW = 12;
   localparam logic [MinRecipW-1:0] MinRecip =
      MinRecipW'((32'd1 << MinShift) / 32'd60);
   localparam int MinProdW  = TodWidth + MinRecipW;
   localparam int HourShift = 11;
   localparam int HourRecipW = 6;
   localparam logic [HourRecipW-1:0] HourRecip =
      HourRecipW'((32'd1 << HourShift) / 32'd60);
   localparam int HourProdW = MinOfDayWidth + HourRecipW;
   localparam int RemWidth  = 7;

   logic [MinProdW-1:0]      min_prod;
   logic [MinOfDayWidth-1:0] min_est_ff;
   logic [TodWidth-1:0]      tod_ff;
   logic [TodWidth-1:0]      sec_rem_wide;
   logic [RemWidth-1:0]      sec_rem;
   logic                     sec_fix;
   logic [MinOfDayWidth-1:0] mins_in;
   logic [SecondWidth-1:0]   sec_in;
   logic [MinOfDayWidth-1:0] mins_ff;
   logic [SecondWidth-1:0]   sec4_ff;
   logic [HourProdW-1:0]     hour_prod;
   logic [HourWidth-1:0]     hour_est_ff;
   logic [MinOfDayWidth-1:0] mins5_ff;
   logic [SecondWidth-1:0]   sec5_ff;
   logic [MinOfDayWidth-1:0] min_rem_wide;
   logic [RemWidth-1:0]      min_rem;
   logic                     min_fix;
   logic [HourWidth-1:0]     hour_in;
   logic [MinuteWidth-1:0]   minute_in;
   logic [HourWidth-1:0]     hour_ff;
   logic [MinuteWidth-1:0]   minute_ff;
   logic [SecondWidth-1:0]   second_ff;

   // Stage 3: estimate minute of day
   assign min_prod = MinProdW'(tod) * MinProdW'(MinRecip);

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         min_est_ff <= min_prod[MinShift +: MinOfDayWidth];
         tod_ff     <= tod;
      end
   end

   // Stage 4: correct minute of day, split off seconds
   always_comb begin
      sec_rem_wide = tod_ff - TodWidth'(min_est_ff) * TodWidth'(SecsPerMinute);
      sec_rem      = sec_rem_wide[RemWidth-1:0];
      sec_fix      = sec_rem >= RemWidth'(SecsPerMinute);
      mins_in      = min_est_ff + MinOfDayWidth'(sec_fix);
      sec_in       = SecondWidth'(sec_fix ? sec_rem - RemWidth'(SecsPerMinute) : sec_rem);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         mins_ff <= mins_in;
         sec4_ff <= sec_in;
      end
   end

   // Stage 5: estimate hour
   assign hour_prod = HourProdW'(mins_ff) * HourProdW'(HourRecip);

   always_ff @(posedge clock) begin
      if (ctl.en[4]) begin
         hour_est_ff <= hour_prod[HourShift +: HourWidth];
         mins5_ff    <= mins_ff;
         sec5_ff     <= sec4_ff;
      end
   end

   // Stage 6: correct hour, split off minutes
   always_comb begin
      min_rem_wide = mins5_ff - MinOfDayWidth'(hour_est_ff) * MinOfDayWidth'(MinsPerHour);
      min_rem      = min_rem_wide[RemWidth-1:0];
      min_fix      = min_rem >= RemWidth'(MinsPerHour);
      hour_in      = hour_est_ff + HourWidth'(min_fix);
      minute_in    = MinuteWidth'(min_fix ? min_rem - RemWidth'(MinsPerHour) : min_rem);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[5]) begin
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= sec5_ff;
      end
   end

   assign hour   = hour_ff;
   assign minute = minute_ff;
   assign second = second_ff;

   // Time of day stays in range on every held result
   a_clock_range: assert property (@(posedge clock)
      ctl.valid[NumStages-1] |->
         (hour_ff < HourWidth'(24)) && (minute_ff < MinuteWidth'(60)) &&
         (second_ff < SecondWidth'(60)))
      else $error("time of day out of range");

endmodule

### rtl/esc_date_split.sv
module esc_date_split (
   input  logic                              clock,
   input  esc_pkg::pipe_ctl_type             ctl,
   input  logic [esc_pkg::DaysWidth-1:0]     days,
   output logic [esc_pkg::YearWidth-1:0]     year,
   output logic [esc_pkg::MonthWidth-1:0]    month,
   output logic [esc_pkg::DayWidth-1:0]      day,
   output logic [esc_pkg::WeekdayWidth-1:0]  weekday,
   output logic                              out_of_range
);
   import esc_pkg::*;

   localparam int GroupShift  = 27;
   localparam int GroupRecipW = 17;
   localparam logic [GroupRecipW-1:0] GroupRecip =
      GroupRecipW'((64'd1 << GroupShift) / 64'd1461);
   localparam int GroupProdW  = DaysWidth + GroupRecipW;
   localparam int WeekWidth   = DaysWidth + 1;
   localparam int WeekShift   = 17;
   localparam int WeekRecipW  = 15;
   localparam logic [WeekRecipW-1:0] WeekRecip =
      WeekRecipW'((32'd1 << WeekShift) / 32'd7);
   localparam int WeekProdW   = WeekWidth + WeekRecipW;
   localparam int WeekQuotW   = 14;
   localparam int GrRemWideW  = 12;
   localparam int WkRemW      = 4;

   logic [GroupProdW-1:0]    group_prod;
   logic [WeekWidth-1:0]     week_days;
   logic [WeekProdW-1:0]     week_prod;
   logic [GroupWidth-1:0]    group_est_ff;
   logic [WeekQuotW-1:0]     week_est_ff;
   logic [DaysWidth-1:0]     days3_ff;
   logic                     oor3_ff;

   logic [DaysWidth-1:0]     grp_rem_wide;
   logic [GrRemWideW-1:0]    grp_rem;
   logic                     grp_fix;
   logic [GroupWidth-1:0]    group_in;
   logic [GroupRemWidth-1:0] grp_rem_in;
   logic [WeekWidth-1:0]     week_days4;
   logic [WeekWidth-1:0]     wk_rem_wide;
   logic [WkRemW-1:0]        wk_rem;
   logic [WeekdayWidth-1:0]  weekday_in;
   logic [GroupWidth-1:0]    group_ff;
   logic [GroupRemWidth-1:0] grp_rem_ff;
   logic [WeekdayWidth-1:0]  weekday4_ff;
   logic                     oor4_ff;

   logic [1:0]               year_of_group;
   logic [GroupRemWidth-1:0] year_start;
   logic [GroupRemWidth-1:0] yr_rem_wide;
   logic [YearWidth:0]       year_sum;
   logic [YearWidth-1:0]     year5_ff;
   logic [YearRemWidth-1:0]  yr_rem5_ff;
   logic                     leap5_ff;
   logic [WeekdayWidth-1:0]  weekday5_ff;
   logic                     oor5_ff;

   logic [MonthWidth-1:0]    month_in;
   logic [MonthWidth-1:0]    month_prev;
   cum_day_type              month_start;
   cum_day_type              day_sum;
   logic [YearWidth-1:0]     year_ff;
   logic [MonthWidth-1:0]    month_ff;
   logic [DayWidth-1:0]      day_ff;
   logic [WeekdayWidth-1:0]  weekday_ff;
   logic                     oor_ff;

   // Stage 3: estimate four-year group and week count, flag range
   assign group_prod = GroupProdW'(days) * GroupProdW'(GroupRecip);
   assign week_days  = WeekWidth'(days) + WeekWidth'(FirstWeekday);
   assign week_prod  = WeekProdW'(week_days) * WeekProdW'(WeekRecip);

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         group_est_ff <= group_prod[GroupShift +: GroupWidth];
         week_est_ff  <= week_prod[WeekShift +: WeekQuotW];
         days3_ff     <= days;
         oor3_ff      <= days >= DaysInRange;
      end
   end

   // Stage 4: correct group and weekday
   always_comb begin
      grp_rem_wide = days3_ff - DaysWidth'(group_est_ff) * DaysWidth'(DaysPerGroup);
      grp_rem      = grp_rem_wide[GrRemWideW-1:0];
      grp_fix      = grp_rem >= GrRemWideW'(DaysPerGroup);
      group_in     = group_est_ff + GroupWidth'(grp_fix);
      grp_rem_in   = GroupRemWidth'(grp_fix ? grp_rem - GrRemWideW'(DaysPerGroup) : grp_rem);
      week_days4   = WeekWidth'(days3_ff) + WeekWidth'(FirstWeekday);
      wk_rem_wide  = week_days4 - WeekWidth'(week_est_ff) * WeekWidth'(DaysPerWeek);
      wk_rem       = wk_rem_wide[WkRemW-1:0];
      weekday_in   = WeekdayWidth'(wk_rem >= WkRemW'(DaysPerWeek) ?
                                   wk_rem - WkRemW'(DaysPerWeek) : wk_rem);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         group_ff    <= group_in;
         grp_rem_ff  <= grp_rem_in;
         weekday4_ff <= weekday_in;
         oor4_ff     <= oor3_ff;
      end
   end

   // Stage 5: pick the year within the group
   always_comb begin
      if (grp_rem_ff >= YearStart3) begin
         year_of_group = 2'd3;
         year_start    = YearStart3;
      end else if (grp_rem_ff >= YearStart2) begin
         year_of_group = 2'd2;
         year_start    = YearStart2;
      end else if (grp_rem_ff >= YearStart1) begin
         year_of_group = 2'd1;
         year_start    = YearStart1;
      end else begin
         year_of_group = 2'd0;
         year_start    = '0;
      end
      yr_rem_wide = grp_rem_ff - year_start;
      year_sum    = (YearWidth+1)'({group_ff, 2'b00}) + (YearWidth+1)'(year_of_group);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[4]) begin
         year5_ff    <= year_sum[YearWidth-1:0];
         yr_rem5_ff  <= yr_rem_wide[YearRemWidth-1:0];
         leap5_ff    <= year_of_group == 2'd0;
         weekday5_ff <= weekday4_ff;
         oor5_ff     <= oor4_ff;
      end
   end

   // Stage 6: find the month from the cumulative-day table
   always_comb begin
      month_in = MonthWidth'(12);
      for (int m = 11; m >= 1; m--) begin
         if (yr_rem5_ff < (leap5_ff ? CumLeap[m] : CumCommon[m])) begin
            month_in = MonthWidth'(m);
         end
      end
      month_prev  = month_in - MonthWidth'(1);
      month_start = leap5_ff ? CumLeap[month_prev] : CumCommon[month_prev];
      day_sum     = yr_rem5_ff + YearRemWidth'(1) - month_start;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[5]) begin
         year_ff    <= year5_ff;
         month_ff   <= month_in;
         day_ff     <= day_sum[DayWidth-1:0];
         weekday_ff <= weekday5_ff;
         oor_ff     <= oor5_ff;
      end
   end

   assign year         = year_ff;
   assign month        = month_ff;
   assign day          = day_ff;
   assign weekday      = weekday_ff;
   assign out_of_range = oor_ff;

   // An in-range result carries a real calendar date
   a_date_range: assert property (@(posedge clock)
      (ctl.valid[NumStages-1] && !oor_ff) |->
         (year_ff <= YearWidth'(99)) && (month_ff >= MonthWidth'(1)) &&
         (month_ff <= MonthWidth'(12)) && (day_ff != '0) &&
         (weekday_ff < WeekdayWidth'(DaysPerWeek)))
      else $error("calendar date out of range");

endmodule

### rtl/epoch_seconds_to_calendar.sv
// Channel  Direction  Payload
// -------  ---------  ---------------------------------------------------------
// req_ch   in         seconds_count
// rsp_ch   out        year, month, day, hour, minute, second, weekday, out_of_range
//
// Six register stages; rsp_ch.valid rises once an item has passed through all six.
// One transfer per cycle in both directions while rsp_ch.ready stays high.
// Stall: each stage holds while the next is full and stalled; bubbles collapse.
// Reset clears only the stage valid bits; no result is pending after reset.
module epoch_seconds_to_calendar (
   input logic         clock,
   input logic         reset,
   esc_req_if.sink     req_ch,
   esc_rsp_if.source   rsp_ch
);
   import esc_pkg::*;

   pipe_ctl_type            ctl;
   logic [DaysWidth-1:0]    days;
   logic [TodWidth-1:0]     tod;
   logic [YearWidth-1:0]    year;
   logic [MonthWidth-1:0]   month;
   logic [DayWidth-1:0]     day;
   logic [HourWidth-1:0]    hour;
   logic [MinuteWidth-1:0]  minute;
   logic [SecondWidth-1:0]  second;
   logic [WeekdayWidth-1:0] weekday;
   logic                    oor;

   esc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .ctl       (ctl)
   );

   esc_day_split u_day_split (
      .clock         (clock),
      .ctl           (ctl),
      .seconds_count (req_ch.seconds_count),
      .days          (days),
      .tod           (tod)
   );

   esc_tod_split u_tod_split (
      .clock  (clock),
      .ctl    (ctl),
      .tod    (tod),
      .hour   (hour),
      .minute (minute),
      .second (second)
   );

   esc_date_split u_date_split (
      .clock        (clock),
      .ctl          (ctl),
      .days         (days),
      .year         (year),
      .month        (month),
      .day          (day),
      .weekday      (weekday),
      .out_of_range (oor)
   );

   // Zero every date and time field of a result beyond the end of 2099
   assign rsp_ch.year         = oor ? '0 : year;
   assign rsp_ch.month        = oor ? '0 : month;
   assign rsp_ch.day          = oor ? '0 : day;
   assign rsp_ch.hour         = oor ? '0 : hour;
   assign rsp_ch.minute       = oor ? '0 : minute;
   assign rsp_ch.second       = oor ? '0 : second;
   assign rsp_ch.weekday      = oor ? '0 : weekday;
   assign rsp_ch.out_of_range = oor;

endmodule

### test/epoch_seconds_to_calendar_tb.sv
module epoch_seconds_to_calendar_tb;
   import esc_pkg::*;

   localparam int unsigned DayCountLimit   = 36525;
   localparam int unsigned LastInRangeSecs = 32'd3155759999;
   localparam int unsigned HoldOffCycles   = 300;
   localparam int unsigned WatchdogLimit   = 2000;
   localparam int unsigned PhaseItems      = 450;
   localparam int unsigned PressureItems   = 100;

   // First day of each month, with the year length as the last entry
   localparam int unsigned CommonMonthStart [13] = '{
      0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
   };
   localparam int unsigned LeapMonthStart [13] = '{
      0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366
   };
   localparam int unsigned GroupYearStart [4] = '{0, 366, 731, 1096};

   // Year ends, leap days, the last second of 2099 and the first past it
   localparam logic [SecsWidth-1:0] DirectedSecs [18] = '{
      32'd0,          32'd86399,      32'd45030,      32'd2678400,
      32'd5097600,    32'd5184000,    32'd31622399,   32'd31622400,
      32'd36720000,   32'd94694399,   32'd126230400,  32'd131328000,
      32'd3155759999, 32'd3155760000, 32'd3155760001, 32'hFFFF_FFFF,
      32'hAAAA_AAAA,  32'h5555_5555
   };

   typedef struct packed {
      logic [YearWidth-1:0]    year;
      logic [MonthWidth-1:0]   month;
      logic [DayWidth-1:0]     day;
      logic [HourWidth-1:0]    hour;
      logic [MinuteWidth-1:0]  minute;
      logic [SecondWidth-1:0]  second;
      logic [WeekdayWidth-1:0] weekday;
      logic                    out_of_range;
   } calendar_type;

   typedef struct {
      logic [SecsWidth-1:0] secs;
      calendar_type         date;
   } pending_date_type;

   class calendar_scoreboard;
      pending_date_type expected_dates[$];
      int unsigned      errors;

      function new();
         errors = 0;
      endfunction

      // Convert a second count into calendar fields
      function calendar_type seconds_to_calendar(logic [SecsWidth-1:0] secs);
         calendar_type r;
         int unsigned  days, tod, rem, yr, m, d, a, yy, mm;
         bit           leap;
         r = '0;
         days = secs / 86400;
         tod = secs % 86400;
         if (days >= DayCountLimit) begin
            r.out_of_range = 1'b1;
            return r;
         end
         yr = (days / 1461) * 4;
         rem = days % 1461;
         for (int j = 3; j > 0; j--) begin
            if (rem >= GroupYearStart[j]) begin
               yr += j;
               rem -= GroupYearStart[j];
               break;
            end
         end
         leap = (yr % 4 == 0);
         m = 1;
         while (rem >= (leap ? LeapMonthStart[m] : CommonMonthStart[m])) m++;
         d = rem + 1 - (leap ? LeapMonthStart[m-1] : CommonMonthStart[m-1]);
         // Gregorian day of week on the full year, January/February count as last year
         a = (14 - m) / 12;
         yy = 2000 + yr - a;
         mm = m + 12 * a - 2;
         r.year    = YearWidth'(yr);
         r.month   = MonthWidth'(m);
         r.day     = DayWidth'(d);
         r.hour    = HourWidth'(tod / 3600);
         r.minute  = MinuteWidth'((tod % 3600) / 60);
         r.second  = SecondWidth'(tod % 60);
         r.weekday = WeekdayWidth'((d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7);
         return r;
      endfunction

      function void note_input(logic [SecsWidth-1:0] secs);
         pending_date_type entry;
         entry.secs = secs;
         entry.date = seconds_to_calendar(secs);
         expected_dates.push_back(entry);
      endfunction

      function int unsigned pending();
         return expected_dates.size();
      endfunction

      function void compare_field(string field, logic [SecsWidth-1:0] secs,
                                  int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch for seconds %0d: expected %0d, actual %0d",
                     $time, field, secs, want, got);
         end
      endfunction

      function void check_result(calendar_type got);
         pending_date_type want;
         if (expected_dates.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %p", $time, got);
            return;
         end
         want = expected_dates.pop_front();
         compare_field("year", want.secs, want.date.year, got.year);
         compare_field("month", want.secs, want.date.month, got.month);
         compare_field("day", want.secs, want.date.day, got.day);
         compare_field("hour", want.secs, want.date.hour, got.hour);
         compare_field("minute", want.secs, want.date.minute, got.minute);
         compare_field("second", want.secs, want.date.second, got.second);
         compare_field("weekday", want.secs, want.date.weekday, got.weekday);
         compare_field("out_of_range", want.secs, want.date.out_of_range, got.out_of_range);
      endfunction
   endclass

   logic clock;
   logic reset;

   esc_req_if req_ch ();
   esc_rsp_if rsp_ch ();

   epoch_seconds_to_calendar i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   calendar_scoreboard sb = new();

   int unsigned  rsp_stall_pct = 0;
   int unsigned  hold_request  = 0;
   int unsigned  stuck_cycles  = 0;
   calendar_type observed;

   // Free-running clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Drive result ready: long hold-off on request, else random stalls
   initial begin : drive_rsp_ready
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Record input transfers, check result transfers, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            observed.year         = rsp_ch.year;
            observed.month        = rsp_ch.month;
            observed.day          = rsp_ch.day;
            observed.hour         = rsp_ch.hour;
            observed.minute       = rsp_ch.minute;
            observed.second       = rsp_ch.second;
            observed.weekday      = rsp_ch.weekday;
            observed.out_of_range = rsp_ch.out_of_range;
            sb.check_result(observed);
         end
         if (req_ch.valid && req_ch.ready) sb.note_input(req_ch.seconds_count);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
         if (stuck_cycles >= WatchdogLimit) begin
            $display("FAIL epoch_seconds_to_calendar");
            $finish;
         end
      end
   end

   // Pick a second count: mostly in range, some on month and year edges,
   // some around the end of 2099, some anywhere
   function automatic logic [SecsWidth-1:0] pick_seconds();
      int unsigned kind, g, y, m, d;
      kind = $urandom_range(99);
      if (kind < 65) return $urandom_range(LastInRangeSecs);
      if (kind < 85) begin
         g = $urandom_range(24);
         y = $urandom_range(3);
         m = $urandom_range(12);
         d = g * 1461 + GroupYearStart[y] + (y == 0 ? LeapMonthStart[m] : CommonMonthStart[m]);
         if (d > 0 && $urandom_range(1) == 1) d--;
         case ($urandom_range(2))
            0: return d * 86400;
            1: return d * 86400 + 86399;
            default: return d * 86400 + $urandom_range(86399);
         endcase
      end
      if (kind < 90) return $urandom_range(LastInRangeSecs + 50000, LastInRangeSecs - 50000);
      return $urandom;
   endfunction

   // Offer one item after a random gap and hold it until the transfer
   task automatic offer_seconds(input logic [SecsWidth-1:0] secs, input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.seconds_count <= secs;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Stop offering and wait until every expected result has come back
   task automatic wait_all_returned();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (NumStages + 2) @(posedge clock);
   endtask

   task automatic run_random(input int unsigned count, input int unsigned idle_pct,
                             input int unsigned stall_pct);
      rsp_stall_pct = stall_pct;
      repeat (count) offer_seconds(pick_seconds(), idle_pct);
      wait_all_returned();
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.seconds_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed edges without idling
      foreach (DirectedSecs[i]) offer_seconds(DirectedSecs[i], 0);
      wait_all_returned();

      run_random(PhaseItems, 0, 0);
      run_random(PhaseItems, 50, 0);
      run_random(PhaseItems, 0, 50);
      run_random(PhaseItems, 32, 32);

      // Hold off the receiver while the sender keeps going, so the pipe fills
      rsp_stall_pct = 0;
      hold_request = HoldOffCycles;
      run_random(PressureItems, 0, 0);

      if (sb.errors == 0) begin
         $display("PASS epoch_seconds_to_calendar");
      end else begin
         $display("FAIL epoch_seconds_to_calendar");
      end
      $finish;
   end

endmodule
